/* sv/bmpr8_pkg.sv */
// Shared constants, codes and types of the BMP RLE8 run decoder.
// Used by every module of the block; depends on nothing.
package bmpr8_pkg;

   localparam int unsigned MAX_WIDTH  = 4096;
   localparam int unsigned MAX_HEIGHT = 4096;

   localparam longint unsigned FRAME_MAX = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);

   localparam int CFG_W   = 13;
   localparam int CSR_IDX_W = 2;
   localparam int CODE_W  = 8;
   localparam int ADDR_W  = 24;
   localparam int WID_W   = $clog2(MAX_WIDTH + 1);
   localparam int HGT_W   = $clog2(MAX_HEIGHT + 1);
   localparam int TOT_W   = $clog2(FRAME_MAX + 1);
   localparam int ROWS_W  = CODE_W + WID_W;
   localparam int SUM_W   = ((TOT_W > ROWS_W) ? TOT_W : ROWS_W) + 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = CSR_IDX_W'(1);

   localparam logic [CODE_W-1:0] ESC_END_LINE   = CODE_W'(0);
   localparam logic [CODE_W-1:0] ESC_END_BITMAP = CODE_W'(1);
   localparam logic [CODE_W-1:0] ESC_DELTA      = CODE_W'(2);

   typedef enum logic [2:0] {
      PH_COUNT   = 3'd0,
      PH_INDEX   = 3'd1,
      PH_ESCAPE  = 3'd2,
      PH_DX      = 3'd3,
      PH_DY      = 3'd4,
      PH_LITERAL = 3'd5,
      PH_PAD     = 3'd6
   } phase_type;

   typedef struct packed {
      logic [WID_W-1:0] width;
      logic [TOT_W-1:0] total;
   } cfg_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              last;
      logic              start;
      logic [ROWS_W-1:0] rows;
   } item_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [CODE_W-1:0] len;
      logic [CODE_W-1:0] color;
      logic              done;
      logic              ovf;
   } result_type;

endpackage

/* sv/bmpr8_csr.sv */
// Configuration registers: clamped image width and height and the frame size.
// Depends on bmpr8_pkg.
module bmpr8_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bmpr8_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bmpr8_pkg::CFG_W-1:0]          csr_wdata,
   output bmpr8_pkg::cfg_type                   cfg
);

   localparam int PROD_W = bmpr8_pkg::WID_W + bmpr8_pkg::HGT_W;

   logic [bmpr8_pkg::WID_W-1:0] width_ff, width_in;
   logic [bmpr8_pkg::HGT_W-1:0] height_ff, height_in;
   logic [bmpr8_pkg::TOT_W-1:0] total_ff;
   logic [PROD_W-1:0]           total_in;
   logic                        wr_width, wr_height;

   function automatic logic [bmpr8_pkg::WID_W-1:0] clamp_width(
      input logic [bmpr8_pkg::CFG_W-1:0] v);
      logic [bmpr8_pkg::WID_W-1:0] r;
      if (v == '0) begin
         r = bmpr8_pkg::WID_W'(1);
      end else if (32'(v) > bmpr8_pkg::MAX_WIDTH) begin
         r = bmpr8_pkg::WID_W'(bmpr8_pkg::MAX_WIDTH);
      end else begin
         r = bmpr8_pkg::WID_W'(v);
      end
      return r;
   endfunction

   function automatic logic [bmpr8_pkg::HGT_W-1:0] clamp_height(
      input logic [bmpr8_pkg::CFG_W-1:0] v);
      logic [bmpr8_pkg::HGT_W-1:0] r;
      if (v == '0) begin
         r = bmpr8_pkg::HGT_W'(1);
      end else if (32'(v) > bmpr8_pkg::MAX_HEIGHT) begin
         r = bmpr8_pkg::HGT_W'(bmpr8_pkg::MAX_HEIGHT);
      end else begin
         r = bmpr8_pkg::HGT_W'(v);
      end
      return r;
   endfunction

   assign csr_ready = 1'b1;
   assign wr_width  = csr_valid && (csr_index == bmpr8_pkg::CSR_IMAGE_WIDTH);
   assign wr_height = csr_valid && (csr_index == bmpr8_pkg::CSR_IMAGE_HEIGHT);

   always_comb begin
      width_in  = wr_width  ? clamp_width(csr_wdata)  : width_ff;
      height_in = wr_height ? clamp_height(csr_wdata) : height_ff;
      total_in  = PROD_W'(width_in) * PROD_W'(height_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bmpr8_pkg::WID_W'(1);
         height_ff <= bmpr8_pkg::HGT_W'(1);
         total_ff  <= bmpr8_pkg::TOT_W'(1);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         total_ff  <= bmpr8_pkg::TOT_W'(total_in);
      end
   end

   assign cfg.width = width_ff;
   assign cfg.total = total_ff;

endmodule

/* sv/bmpr8_front.sv */
// Input register: holds one request and precomputes the delta row offset.
// Depends on bmpr8_pkg.
module bmpr8_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [bmpr8_pkg::CODE_W-1:0]    req_code_byte,
   input  logic                            req_final_byte,
   input  logic                            req_start_frame,
   input  bmpr8_pkg::cfg_type              cfg,
   input  logic                            fire,
   output logic                            item_valid,
   output bmpr8_pkg::item_type             item
);

   logic                valid_ff, valid_in;
   bmpr8_pkg::item_type item_ff, item_in;
   logic                take;

   assign req_stall = valid_ff && !fire;
   assign take      = req_valid && !req_stall;
   assign valid_in  = take || (valid_ff && !fire);

   always_comb begin
      item_in.code  = req_code_byte;
      item_in.last  = req_final_byte;
      item_in.start = req_start_frame;
      item_in.rows  = bmpr8_pkg::ROWS_W'(req_code_byte) * bmpr8_pkg::ROWS_W'(cfg.width);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* sv/bmpr8_core.sv */
// Decode state and the per-byte update: phase, cursor, row start, literals.
// Depends on bmpr8_pkg.
module bmpr8_core (
   input  logic                     clock,
   input  logic                     reset,
   input  bmpr8_pkg::cfg_type       cfg,
   input  logic                     item_valid,
   input  bmpr8_pkg::item_type      item,
   input  logic                     out_free,
   output logic                     fire,
   output logic                     res_valid,
   output bmpr8_pkg::result_type    res
);

   localparam int SW = bmpr8_pkg::SUM_W;
   localparam int TW = bmpr8_pkg::TOT_W;
   localparam int CW = bmpr8_pkg::CODE_W;

   bmpr8_pkg::phase_type phase_ff, phase_in, phase_cur;
   logic [TW-1:0] cursor_ff;
   logic [TW-1:0] row_ff;
   logic [CW-1:0] pend_ff, pend_in, pend_cur;
   logic [CW-1:0] lit_ff, lit_in, lit_cur, lit_dec;
   logic          pad_ff, pad_in, pad_cur;
   logic [CW-1:0] dcol_ff, dcol_in, dcol_cur;
   logic          fin_ff, fin_in, fin_cur;

   logic [SW-1:0] cur_s, row_s, tot, wid, rows, room, len_s, target, row_t;
   logic [SW-1:0] cursor_n, row_n, addr_s;
   logic          over, emit, done, ovf;
   logic [CW-1:0] color;

   assign fire = item_valid && out_free;

   always_comb begin
      phase_cur = item.start ? bmpr8_pkg::PH_COUNT : phase_ff;
      cur_s     = item.start ? '0 : SW'(cursor_ff);
      row_s     = item.start ? '0 : SW'(row_ff);
      pend_cur  = item.start ? '0 : pend_ff;
      lit_cur   = item.start ? '0 : lit_ff;
      pad_cur   = item.start ? 1'b0 : pad_ff;
      dcol_cur  = item.start ? '0 : dcol_ff;
      fin_cur   = item.start ? 1'b0 : fin_ff;
      tot       = SW'(cfg.total);
      wid       = SW'(cfg.width);
      rows      = SW'(item.rows);
      over      = cur_s >= tot;
      lit_dec   = lit_cur - CW'(1);
   end

   // datapath and result
   always_comb begin
      cursor_n = cur_s;
      row_n    = row_s;
      pend_in  = pend_cur;
      lit_in   = lit_cur;
      pad_in   = pad_cur;
      dcol_in  = dcol_cur;
      fin_in   = fin_cur;
      emit     = 1'b0;
      done     = 1'b0;
      ovf      = 1'b0;
      color    = '0;
      len_s    = '0;
      room     = tot - cur_s;
      target   = '0;
      row_t    = '0;
      if (!fin_cur) begin
         if (over) begin
            cursor_n = tot;
            done     = 1'b1;
         end else begin
            unique case (phase_cur)
               bmpr8_pkg::PH_COUNT: begin
                  if (item.code != '0) begin
                     pend_in = item.code;
                  end
               end
               bmpr8_pkg::PH_INDEX: begin
                  len_s = SW'(pend_cur);
                  if (len_s > room) begin
                     len_s = room;
                     ovf   = 1'b1;
                  end
                  emit     = 1'b1;
                  color    = item.code;
                  cursor_n = cur_s + len_s;
                  done     = (cursor_n == tot);
               end
               bmpr8_pkg::PH_ESCAPE: begin
                  if (item.code == bmpr8_pkg::ESC_END_LINE) begin
                     target = row_s + wid;
                     if (target > tot) begin
                        target = tot;
                        ovf    = 1'b1;
                     end
                     row_n    = target;
                     cursor_n = target;
                     done     = (target == tot);
                  end else if (item.code == bmpr8_pkg::ESC_END_BITMAP) begin
                     done = 1'b1;
                  end else if (item.code != bmpr8_pkg::ESC_DELTA) begin
                     lit_in = item.code;
                     pad_in = item.code[0];
                  end
               end
               bmpr8_pkg::PH_DX: begin
                  dcol_in = item.code;
               end
               bmpr8_pkg::PH_DY: begin
                  target = cur_s + SW'(dcol_cur) + rows;
                  row_t  = row_s + rows;
                  row_n  = (row_t > tot) ? tot : row_t;
                  if (target > tot) begin
                     target = tot;
                     ovf    = 1'b1;
                  end
                  cursor_n = target;
                  done     = (target == tot);
               end
               bmpr8_pkg::PH_LITERAL: begin
                  emit     = 1'b1;
                  len_s    = SW'(1);
                  color    = item.code;
                  cursor_n = cur_s + SW'(1);
                  done     = (cursor_n == tot);
                  lit_in   = lit_dec;
               end
               default: begin
               end
            endcase
         end
         if (item.last) begin
            done = 1'b1;
         end
         if (done) begin
            fin_in = 1'b1;
         end
      end
      addr_s    = emit ? cur_s : cursor_n;
      res_valid = !fin_cur && (emit || done);
      res.addr  = bmpr8_pkg::ADDR_W'(addr_s);
      res.len   = CW'(len_s);
      res.color = color;
      res.done  = done;
      res.ovf   = ovf;
   end

   // next phase
   always_comb begin
      phase_in = phase_cur;
      if (!fin_cur) begin
         if (over) begin
            phase_in = bmpr8_pkg::PH_COUNT;
         end else begin
            unique case (phase_cur)
               bmpr8_pkg::PH_COUNT: begin
                  phase_in = (item.code == '0) ? bmpr8_pkg::PH_ESCAPE : bmpr8_pkg::PH_INDEX;
               end
               bmpr8_pkg::PH_ESCAPE: begin
                  if (item.code == bmpr8_pkg::ESC_END_LINE ||
                      item.code == bmpr8_pkg::ESC_END_BITMAP) begin
                     phase_in = bmpr8_pkg::PH_COUNT;
                  end else if (item.code == bmpr8_pkg::ESC_DELTA) begin
                     phase_in = bmpr8_pkg::PH_DX;
                  end else begin
                     phase_in = bmpr8_pkg::PH_LITERAL;
                  end
               end
               bmpr8_pkg::PH_DX: begin
                  phase_in = bmpr8_pkg::PH_DY;
               end
               bmpr8_pkg::PH_LITERAL: begin
                  if (lit_dec == '0) begin
                     phase_in = pad_cur ? bmpr8_pkg::PH_PAD : bmpr8_pkg::PH_COUNT;
                  end
               end
               default: begin
                  phase_in = bmpr8_pkg::PH_COUNT;
               end
            endcase
         end
         if (done) begin
            phase_in = bmpr8_pkg::PH_COUNT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= bmpr8_pkg::PH_COUNT;
         cursor_ff <= '0;
         row_ff    <= '0;
         pend_ff   <= '0;
         lit_ff    <= '0;
         pad_ff    <= 1'b0;
         dcol_ff   <= '0;
         fin_ff    <= 1'b0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         cursor_ff <= TW'(cursor_n);
         row_ff    <= TW'(row_n);
         pend_ff   <= pend_in;
         lit_ff    <= lit_in;
         pad_ff    <= pad_in;
         dcol_ff   <= dcol_in;
         fin_ff    <= fin_in;
      end
   end

`ifndef SYNTH
   a_run_in_frame: assert property (@(posedge clock) disable iff (reset)
      (fire && emit && !fin_cur) |-> (cur_s + len_s <= tot))
      else $error("run extends past frame end");

   a_done_latches: assert property (@(posedge clock) disable iff (reset)
      (fire && res_valid && res.done) |=> fin_ff)
      else $error("frame end not recorded");

   a_quiet_after_end: assert property (@(posedge clock) disable iff (reset)
      (fire && fin_ff && !item.start) |-> !res_valid)
      else $error("result after frame end");
`endif

endmodule

/* sv/bmpr8_out.sv */
// Result register with stall handshake toward the receiver.
// Depends on bmpr8_pkg.
module bmpr8_out (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  bmpr8_pkg::result_type           res,
   output logic                            out_free,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bmpr8_pkg::ADDR_W-1:0]    rsp_pixel_address,
   output logic [bmpr8_pkg::CODE_W-1:0]    rsp_run_length,
   output logic [bmpr8_pkg::CODE_W-1:0]    rsp_color_index,
   output logic                            rsp_frame_done,
   output logic                            rsp_overflow
);

   logic                  valid_ff, valid_in;
   bmpr8_pkg::result_type res_ff;

   assign out_free = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_pixel_address = res_ff.addr;
   assign rsp_run_length    = res_ff.len;
   assign rsp_color_index   = res_ff.color;
   assign rsp_frame_done    = res_ff.done;
   assign rsp_overflow      = res_ff.ovf;

endmodule

/* sv/bmp_rle8_run_decoder.sv */
// BMP RLE8 run decoder top level: CSR block, input register, decode core,
// result register. Depends on bmpr8_pkg and the bmpr8_* modules.
//
// Usage: write image_width (index 0) and image_height (index 1) on the csr_
// channel while the block is idle; csr_ready is always high and the values
// take effect on the next cycle. Then feed the compressed stream one byte
// per request on req_ (req_start_frame on the first byte of a frame,
// req_final_byte on the last). Each byte yields zero or one response on rsp_:
// a run or literal pixel at a linear address, or a frame-done marker.
// Path: an accepted request is held in the input register, decoded by the
// combinational core and loaded into the result register, which presents it.
// Throughput: one request per cycle unless rsp_stall holds a waiting response;
// the core updates its state in the same cycle it reads it; bytes need no gap.
// Stall: while rsp_stall holds a waiting response, the core holds the request
// in the input register and raises req_stall; one request is still taken
// while the result register is full. Bytes that give no response pass
// through only when the result register is free.
// Reset: synchronous; clears the handshakes, the decode state and sets both
// dimensions to 1.
module bmp_rle8_run_decoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bmpr8_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bmpr8_pkg::CFG_W-1:0]     csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [bmpr8_pkg::CODE_W-1:0]    req_code_byte,
   input  logic                            req_final_byte,
   input  logic                            req_start_frame,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bmpr8_pkg::ADDR_W-1:0]    rsp_pixel_address,
   output logic [bmpr8_pkg::CODE_W-1:0]    rsp_run_length,
   output logic [bmpr8_pkg::CODE_W-1:0]    rsp_color_index,
   output logic                            rsp_frame_done,
   output logic                            rsp_overflow
);

   bmpr8_pkg::cfg_type    cfg;
   bmpr8_pkg::item_type   item;
   bmpr8_pkg::result_type res;
   logic                  item_valid, fire, res_valid, out_free, load;

   assign load = fire && res_valid;

   bmpr8_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bmpr8_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_code_byte   (req_code_byte),
      .req_final_byte  (req_final_byte),
      .req_start_frame (req_start_frame),
      .cfg             (cfg),
      .fire            (fire),
      .item_valid      (item_valid),
      .item            (item)
   );

   bmpr8_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .out_free   (out_free),
      .fire       (fire),
      .res_valid  (res_valid),
      .res        (res)
   );

   bmpr8_out u_out (
      .clock             (clock),
      .reset             (reset),
      .load              (load),
      .res               (res),
      .out_free          (out_free),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_run_length    (rsp_run_length),
      .rsp_color_index   (rsp_color_index),
      .rsp_frame_done    (rsp_frame_done),
      .rsp_overflow      (rsp_overflow)
   );

endmodule

/* bench/bmp_rle8_run_decoder_tb.sv */
// Self-checking bench for bmp_rle8_run_decoder: random-stall stream driver,
// in-bench decode predictor and in-order result scoreboard.
// Depends on bmpr8_pkg and the bmp_rle8_run_decoder RTL.
module bmp_rle8_run_decoder_tb;

   localparam int unsigned QUIET_LIMIT = 1500;
   localparam int unsigned RANDOM_BYTES = 1800;
   localparam int unsigned CALM_AFTER = 1500;
   localparam logic [bmpr8_pkg::CODE_W-1:0] ESC_MARK = 8'h00;
   localparam logic [bmpr8_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [bmpr8_pkg::CODE_W-1:0] code;
      logic                         last;
      logic                         start;
   } code_item_type;

   class rle8_scoreboard;
      logic [bmpr8_pkg::CFG_W-1:0]  width_reg;
      logic [bmpr8_pkg::CFG_W-1:0]  height_reg;
      bmpr8_pkg::phase_type         phase;
      longint unsigned              cursor;
      longint unsigned              row_base;
      logic [bmpr8_pkg::CODE_W-1:0] run_count;
      logic [bmpr8_pkg::CODE_W-1:0] lits_left;
      logic [bmpr8_pkg::CODE_W-1:0] dx;
      bit                           pad;
      bit                           finished;
      bmpr8_pkg::result_type        expected_writes[$];
      int                           errors;
      int                           pixel_writes;
      int                           frames_ended;
      int                           clipped;

      function new();
         width_reg = bmpr8_pkg::CFG_W'(1);
         height_reg = bmpr8_pkg::CFG_W'(1);
         errors = 0;
         pixel_writes = 0;
         frames_ended = 0;
         clipped = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         phase = bmpr8_pkg::PH_COUNT;
         cursor = 0;
         row_base = 0;
         run_count = '0;
         lits_left = '0;
         dx = '0;
         pad = 0;
         finished = 0;
      endfunction

      function void write_reg(logic [bmpr8_pkg::CSR_IDX_W-1:0] idx,
                              logic [bmpr8_pkg::CFG_W-1:0] val);
         if (idx == bmpr8_pkg::CSR_IMAGE_WIDTH) width_reg = val;
         else if (idx == bmpr8_pkg::CSR_IMAGE_HEIGHT) height_reg = val;
      endfunction

      function longint unsigned row_width();
         longint unsigned w;
         w = 64'(width_reg);
         if (w < 1) w = 1;
         if (w > 64'(bmpr8_pkg::MAX_WIDTH)) w = 64'(bmpr8_pkg::MAX_WIDTH);
         return w;
      endfunction

      function longint unsigned frame_size();
         longint unsigned h;
         h = 64'(height_reg);
         if (h < 1) h = 1;
         if (h > 64'(bmpr8_pkg::MAX_HEIGHT)) h = 64'(bmpr8_pkg::MAX_HEIGHT);
         return row_width() * h;
      endfunction

      // Returns 0 when the byte is dropped because the frame has already ended.
      function bit note_byte(logic [bmpr8_pkg::CODE_W-1:0] code, logic last, logic start);
         longint unsigned tot, w, target, room, rows, addr, len;
         logic [bmpr8_pkg::CODE_W-1:0] color;
         bit emit, done, ovf;
         bmpr8_pkg::result_type r;
         emit = 0;
         done = 0;
         ovf = 0;
         addr = 0;
         len = 0;
         color = '0;
         if (start) clear_frame();
         if (finished) return 0;
         w = row_width();
         tot = frame_size();
         if (cursor >= tot) begin
            cursor = tot;
            done = 1;
         end else begin
            case (phase)
               bmpr8_pkg::PH_COUNT: begin
                  if (code == ESC_MARK) begin
                     phase = bmpr8_pkg::PH_ESCAPE;
                  end else begin
                     run_count = code;
                     phase = bmpr8_pkg::PH_INDEX;
                  end
               end
               bmpr8_pkg::PH_INDEX: begin
                  room = tot - cursor;
                  len = 64'(run_count);
                  if (len > room) begin
                     len = room;
                     ovf = 1;
                  end
                  addr = cursor;
                  color = code;
                  emit = 1;
                  cursor += len;
                  if (cursor == tot) done = 1;
                  phase = bmpr8_pkg::PH_COUNT;
               end
               bmpr8_pkg::PH_ESCAPE: begin
                  phase = bmpr8_pkg::PH_COUNT;
                  if (code == bmpr8_pkg::ESC_END_LINE) begin
                     target = row_base + w;
                     if (target > tot) begin
                        target = tot;
                        ovf = 1;
                     end
                     row_base = target;
                     cursor = target;
                     if (target == tot) done = 1;
                  end else if (code == bmpr8_pkg::ESC_END_BITMAP) begin
                     done = 1;
                  end else if (code == bmpr8_pkg::ESC_DELTA) begin
                     phase = bmpr8_pkg::PH_DX;
                  end else begin
                     lits_left = code;
                     pad = code[0];
                     phase = bmpr8_pkg::PH_LITERAL;
                  end
               end
               bmpr8_pkg::PH_DX: begin
                  dx = code;
                  phase = bmpr8_pkg::PH_DY;
               end
               bmpr8_pkg::PH_DY: begin
                  rows = w * 64'(code);
                  target = cursor + 64'(dx) + rows;
                  row_base += rows;
                  if (row_base > tot) row_base = tot;
                  if (target > tot) begin
                     target = tot;
                     ovf = 1;
                  end
                  cursor = target;
                  if (target == tot) done = 1;
                  phase = bmpr8_pkg::PH_COUNT;
               end
               bmpr8_pkg::PH_LITERAL: begin
                  addr = cursor;
                  len = 1;
                  color = code;
                  emit = 1;
                  cursor += 1;
                  if (cursor == tot) done = 1;
                  lits_left = lits_left - 8'd1;
                  if (lits_left == 0)
                     phase = pad ? bmpr8_pkg::PH_PAD : bmpr8_pkg::PH_COUNT;
               end
               default: phase = bmpr8_pkg::PH_COUNT;
            endcase
         end
         if (last) done = 1;
         if (done) begin
            finished = 1;
            phase = bmpr8_pkg::PH_COUNT;
         end
         if (!emit && !done) return 1;
         if (!emit) addr = cursor;
         r.addr = addr[bmpr8_pkg::ADDR_W-1:0];
         r.len = len[bmpr8_pkg::CODE_W-1:0];
         r.color = color;
         r.done = done;
         r.ovf = ovf;
         expected_writes.push_back(r);
         if (emit) pixel_writes++;
         if (done) frames_ended++;
         if (ovf) clipped++;
         return 1;
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_write(bmpr8_pkg::result_type got);
         bmpr8_pkg::result_type want;
         if (expected_writes.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, got addr %0d len %0d",
                     $time, got.addr, got.len);
            $display("%0t: unexpected response color %0d done %0d ovf %0d",
                     $time, got.color, got.done, got.ovf);
            return;
         end
         want = expected_writes.pop_front();
         compare_field("pixel_address", 64'(want.addr), 64'(got.addr));
         compare_field("run_length", 64'(want.len), 64'(got.len));
         compare_field("color_index", 64'(want.color), 64'(got.color));
         compare_field("frame_done", 64'(want.done), 64'(got.done));
         compare_field("overflow", 64'(want.ovf), 64'(got.ovf));
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [bmpr8_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [bmpr8_pkg::CFG_W-1:0]       csr_wdata = '0;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [bmpr8_pkg::CODE_W-1:0]      req_code_byte = '0;
   logic                              req_final_byte = 1'b0;
   logic                              req_start_frame = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [bmpr8_pkg::ADDR_W-1:0]      rsp_pixel_address;
   logic [bmpr8_pkg::CODE_W-1:0]      rsp_run_length;
   logic [bmpr8_pkg::CODE_W-1:0]      rsp_color_index;
   logic                              rsp_frame_done;
   logic                              rsp_overflow;

   rle8_scoreboard        sb = new();
   bmpr8_pkg::result_type seen;
   code_item_type         frame_bytes[$];
   int unsigned           quiet_cycles = 0;
   int unsigned           bytes_taken = 0;
   int unsigned           gap_odds = 0;
   int unsigned           stall_odds = 0;
   int unsigned           stall_left = 0;

   bmp_rle8_run_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_code_byte    (req_code_byte),
      .req_final_byte   (req_final_byte),
      .req_start_frame  (req_start_frame),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_address(rsp_pixel_address),
      .rsp_run_length   (rsp_run_length),
      .rsp_color_index  (rsp_color_index),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_overflow     (rsp_overflow)
   );

   always #2 clock = ~clock;

   always @(negedge clock) begin
      if (stall_left == 0 && stall_odds != 0 && $urandom_range(stall_odds - 1, 0) == 0)
         stall_left = $urandom_range(12, 1);
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.addr = rsp_pixel_address;
         seen.len = rsp_run_length;
         seen.color = rsp_color_index;
         seen.done = rsp_frame_done;
         seen.ovf = rsp_overflow;
         sb.check_write(seen);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL");
      $finish;
   end

   task automatic write_reg(logic [bmpr8_pkg::CSR_IDX_W-1:0] idx,
                            logic [bmpr8_pkg::CFG_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_byte(logic [bmpr8_pkg::CODE_W-1:0] code, logic last, logic start);
      int unsigned gap;
      if (gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0) begin
         gap = $urandom_range(12, 1);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_code_byte <= code;
      req_final_byte <= last;
      req_start_frame <= start;
      do @(posedge clock); while (req_stall);
      void'(sb.note_byte(code, last, start));
      bytes_taken++;
   endtask

   // drain every outstanding response, then give in-flight no-response bytes time to retire
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_writes.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   function automatic void add_byte(logic [bmpr8_pkg::CODE_W-1:0] code);
      code_item_type it;
      it.code = code;
      it.last = ($urandom_range(149, 0) == 0);
      it.start = ($urandom_range(99, 0) == 0);
      frame_bytes.push_back(it);
   endfunction

   function automatic void build_frame();
      int unsigned segs;
      int unsigned n;
      frame_bytes.delete();
      segs = $urandom_range(12, 1);
      repeat (segs) begin
         case ($urandom_range(9, 0))
            0, 1, 2, 3: begin
               n = ($urandom_range(7, 0) == 0) ? $urandom_range(255, 1) : $urandom_range(12, 1);
               add_byte(8'(n));
               add_byte(8'($urandom));
            end
            4, 5: begin
               n = ($urandom_range(11, 0) == 0) ? $urandom_range(255, 3) : $urandom_range(12, 3);
               add_byte(ESC_MARK);
               add_byte(8'(n));
               repeat (n) add_byte(8'($urandom));
               if (n[0]) add_byte(8'($urandom));
            end
            6: begin
               add_byte(ESC_MARK);
               add_byte(bmpr8_pkg::ESC_END_LINE);
            end
            7: begin
               add_byte(ESC_MARK);
               add_byte(bmpr8_pkg::ESC_DELTA);
               add_byte(($urandom_range(7, 0) == 0) ? 8'($urandom) : 8'($urandom_range(10, 0)));
               add_byte(($urandom_range(7, 0) == 0) ? 8'($urandom) : 8'($urandom_range(3, 0)));
            end
            8: begin
               if ($urandom_range(3, 0) == 0) begin
                  add_byte(ESC_MARK);
                  add_byte(bmpr8_pkg::ESC_END_BITMAP);
               end else begin
                  add_byte(8'($urandom));
               end
            end
            default: add_byte(8'($urandom));
         endcase
      end
      frame_bytes[0].start = ($urandom_range(7, 0) != 0);
      if ($urandom_range(2, 0) == 0) frame_bytes[$].last = 1'b1;
   endfunction

   function automatic logic [bmpr8_pkg::CFG_W-1:0] pick_dim(int unsigned small_max);
      case ($urandom_range(11, 0))
         0: return '0;
         1: return bmpr8_pkg::CFG_W'(1);
         2: return bmpr8_pkg::CFG_W'(bmpr8_pkg::MAX_WIDTH);
         3: return '1;
         4: return bmpr8_pkg::CFG_W'($urandom_range(8191, 4097));
         default: return bmpr8_pkg::CFG_W'($urandom_range(small_max, 1));
      endcase
   endfunction

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      gap_odds = 4;
      stall_odds = 4;

      write_reg(bmpr8_pkg::CSR_IMAGE_WIDTH, 13'd8);
      write_reg(bmpr8_pkg::CSR_IMAGE_HEIGHT, 13'd4);
      write_reg(CSR_SPARE, 13'h1555);
      send_byte(8'h03, 1'b0, 1'b1);
      send_byte(8'hAA, 1'b0, 1'b0);
      send_byte(ESC_MARK, 1'b0, 1'b0);
      send_byte(bmpr8_pkg::ESC_END_LINE, 1'b0, 1'b0);
      send_byte(ESC_MARK, 1'b0, 1'b0);
      send_byte(bmpr8_pkg::ESC_DELTA, 1'b0, 1'b0);
      send_byte(8'h02, 1'b0, 1'b0);
      send_byte(8'h01, 1'b0, 1'b0);
      send_byte(ESC_MARK, 1'b0, 1'b0);
      send_byte(8'h03, 1'b0, 1'b0);
      send_byte(8'h11, 1'b0, 1'b0);
      send_byte(8'h22, 1'b0, 1'b0);
      send_byte(8'h33, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'h77, 1'b0, 1'b0);
      send_byte(8'h05, 1'b0, 1'b0);
      send_byte(ESC_MARK, 1'b0, 1'b1);
      send_byte(bmpr8_pkg::ESC_END_BITMAP, 1'b0, 1'b0);
      send_byte(ESC_MARK, 1'b0, 1'b1);
      send_byte(bmpr8_pkg::ESC_DELTA, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'h04, 1'b0, 1'b1);
      send_byte(8'h09, 1'b1, 1'b0);
      send_byte(8'h07, 1'b1, 1'b1);
      send_byte(8'h14, 1'b0, 1'b1);
      send_byte(8'h01, 1'b0, 1'b0);
      settle();
      // shrink the frame under the cursor, then continue the same frame
      write_reg(bmpr8_pkg::CSR_IMAGE_HEIGHT, 13'd2);
      send_byte(8'h05, 1'b0, 1'b0);
      settle();

      while (bytes_taken < RANDOM_BYTES) begin
         if (bytes_taken > CALM_AFTER) begin
            gap_odds = 0;
            stall_odds = 0;
         end else begin
            gap_odds = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 2);
            stall_odds = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 2);
         end
         write_reg(bmpr8_pkg::CSR_IMAGE_WIDTH, pick_dim(40));
         write_reg(bmpr8_pkg::CSR_IMAGE_HEIGHT, pick_dim(12));
         repeat ($urandom_range(4, 1)) begin
            build_frame();
            foreach (frame_bytes[i])
               send_byte(frame_bytes[i].code, frame_bytes[i].last, frame_bytes[i].start);
         end
         settle();
      end

      repeat (8) @(posedge clock);
      $display("Decoded %0d bytes: %0d pixel writes, %0d frame ends, %0d clipped.",
               bytes_taken, sb.pixel_writes, sb.frames_ended, sb.clipped);
      if (sb.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* files.f */
sv/bmpr8_pkg.sv
sv/bmpr8_csr.sv
sv/bmpr8_front.sv
sv/bmpr8_core.sv
sv/bmpr8_out.sv
sv/bmp_rle8_run_decoder.sv
bench/bmp_rle8_run_decoder_tb.sv
